>>> src/opbc_pkg.sv
// Shared types and constants for the OLED page blit command generator.
package opbc_pkg;

   localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
   localparam logic [7:0] COL_HI_CMD    = 8'h10;
   localparam logic [3:0] MAX_PAGES     = 4'd8;

   typedef enum logic [1:0] {
      CSR_X_POSITION   = 2'd0,
      CSR_Y_POSITION   = 2'd1,
      CSR_IMAGE_WIDTH  = 2'd2,
      CSR_IMAGE_HEIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] x_position;
      logic [5:0] y_position;
      logic [7:0] image_width;
      logic [6:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic [7:0] page_cmd0;
      logic [7:0] page_cmd1;
      logic [7:0] col_lo_cmd;
      logic [7:0] col_hi_cmd;
      logic [7:0] data0;
      logic [7:0] data1;
      logic       col_end;
   } run_type;

endpackage

>>> src/opbc_group_gen.sv
// Column/page tracking and command group generation for one image byte.
module opbc_group_gen (
   input  logic             clock,
   input  logic             reset,
   input  opbc_pkg::cfg_type cfg,
   input  logic [7:0]       pixel_byte,
   input  logic             advance,
   output opbc_pkg::run_type run
);
   import opbc_pkg::*;

   logic [7:0] column_count_ff, column_count_in;
   logic [3:0] page_count_ff, page_count_in;
   logic [7:0] previous_byte_ff, previous_byte_in;

   logic [7:0]  pages_raw;
   logic [3:0]  pages;
   logic [4:0]  page_next;
   logic        col_end;
   logic [8:0]  col;
   logic [2:0]  shift;
   logic [7:0]  lower;
   logic [15:0] main_word;
   logic [15:0] spill_word;
   logic [7:0]  page_base;
   logic [8:0]  col_next;

   always_comb begin
      pages_raw = ({1'b0, cfg.image_height} + 8'd7) >> 3;
      if (pages_raw == 8'd0) begin
         pages = 4'd1;
      end else if (pages_raw > {4'd0, MAX_PAGES}) begin
         pages = MAX_PAGES;
      end else begin
         pages = pages_raw[3:0];
      end
      page_next  = {1'b0, page_count_ff} + 5'd1;
      col_end    = (page_next >= {1'b0, pages});
      col        = {1'b0, cfg.x_position} + {1'b0, column_count_ff};
      shift      = cfg.y_position[2:0];
      lower      = (page_count_ff == 4'd0) ? 8'd0 : previous_byte_ff;
      main_word  = {pixel_byte, lower} << shift;
      spill_word = {8'd0, pixel_byte} << shift;
      page_base  = PAGE_CMD_BASE + {5'd0, cfg.y_position[5:3]};

      run.page_cmd0  = page_base + {4'd0, page_count_ff};
      run.page_cmd1  = page_base + {3'd0, page_next};
      run.col_lo_cmd = {4'd0, col[3:0]};
      run.col_hi_cmd = COL_HI_CMD | {3'd0, col[8:4]};
      run.data0      = main_word[15:8];
      run.data1      = spill_word[15:8];
      run.col_end    = col_end;

      col_next         = {1'b0, column_count_ff} + 9'd1;
      column_count_in  = column_count_ff;
      page_count_in    = page_count_ff;
      previous_byte_in = previous_byte_ff;
      if (advance) begin
         if (col_end) begin
            page_count_in    = 4'd0;
            previous_byte_in = 8'd0;
            column_count_in  = (col_next >= {1'b0, cfg.image_width}) ? 8'd0 : col_next[7:0];
         end else begin
            page_count_in    = page_next[3:0];
            previous_byte_in = pixel_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff  <= 8'd0;
         page_count_ff    <= 4'd0;
         previous_byte_ff <= 8'd0;
      end else begin
         column_count_ff  <= column_count_in;
         page_count_ff    <= page_count_in;
         previous_byte_ff <= previous_byte_in;
      end
   end

`ifndef SYNTHESIS
   a_page_bound: assert property (@(posedge clock) disable iff (reset)
      page_count_ff <= 4'd7)
      else $error("page counter beyond last page");
   a_first_page_clear: assert property (@(posedge clock) disable iff (reset)
      page_count_ff == 4'd0 |-> previous_byte_ff == 8'd0)
      else $error("spill byte not cleared at column start");
   a_col_end_wrap: assert property (@(posedge clock) disable iff (reset)
      advance && col_end |=> page_count_ff == 4'd0)
      else $error("page counter not reset at column end");
`endif

endmodule

>>> src/opbc_beat_seq.sv
// Result register and beat sequencer for one command group run.
module opbc_beat_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  opbc_pkg::run_type run,
   output logic             free,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_is_data,
   output logic             rsp_last_of_run
);
   import opbc_pkg::*;

   logic    run_valid_ff, run_valid_in;
   logic [2:0] beat_ff, beat_in;
   run_type run_ff;
   logic    take;
   logic    final_beat;

   always_comb begin
      unique case (beat_ff)
         3'd0:    rsp_out_byte = run_ff.page_cmd0;
         3'd1:    rsp_out_byte = run_ff.col_lo_cmd;
         3'd2:    rsp_out_byte = run_ff.col_hi_cmd;
         3'd3:    rsp_out_byte = run_ff.data0;
         3'd4:    rsp_out_byte = run_ff.page_cmd1;
         3'd5:    rsp_out_byte = run_ff.col_lo_cmd;
         3'd6:    rsp_out_byte = run_ff.col_hi_cmd;
         default: rsp_out_byte = run_ff.data1;
      endcase
      rsp_valid       = run_valid_ff;
      rsp_is_data     = (beat_ff[1:0] == 2'd3);
      rsp_last_of_run = (beat_ff == 3'd7) || (beat_ff == 3'd3 && !run_ff.col_end);
      take            = run_valid_ff && rsp_ready;
      final_beat      = take && rsp_last_of_run;
      free            = !run_valid_ff || final_beat;

      run_valid_in = run_valid_ff;
      beat_in      = beat_ff;
      if (load) begin
         run_valid_in = 1'b1;
         beat_in      = 3'd0;
      end else if (final_beat) begin
         run_valid_in = 1'b0;
      end else if (take) begin
         beat_in = beat_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         beat_ff      <= 3'd0;
      end else begin
         run_valid_ff <= run_valid_in;
         beat_ff      <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         run_ff <= run;
      end
   end

`ifndef SYNTHESIS
   a_short_run: assert property (@(posedge clock) disable iff (reset)
      run_valid_ff && !run_ff.col_end |-> beat_ff <= 3'd3)
      else $error("beat index beyond four-beat run");
   a_load_restart: assert property (@(posedge clock) disable iff (reset)
      load |=> run_valid_ff && beat_ff == 3'd0)
      else $error("run not restarted on load");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      final_beat && !load |=> !run_valid_ff)
      else $error("run still valid after last beat");
   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("run overwritten before drained");
`endif

endmodule

>>> src/oled_page_blit_command_generator_core.sv
// Top level of the OLED page blit command generator.
//
//  channel | ports                                   | direction
//  req     | req_valid, req_ready, req_pixel_byte    | in
//  rsp     | rsp_valid, rsp_ready, rsp_out_byte,     | out
//          | rsp_is_data, rsp_last_of_run            |
//  csr     | csr_wr_en, csr_index, csr_wr_data       | in
//
// Each byte yields 4 beats, or 8 at a column end; the output channel sets the pace.
// One byte waits in the input register while the result register drains, so the next
// byte enters on the last beat.
// Synchronous reset clears counters and valid flags and loads the default configuration.
// A stalled rsp_ready holds the current beat; req_ready falls once the input register is full.
module oled_page_blit_command_generator_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_pixel_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_data,
   output logic       rsp_last_of_run,
   input  logic       csr_wr_en,
   input  opbc_pkg::csr_index_type csr_index,
   input  logic [7:0] csr_wr_data
);
   import opbc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       free;
   logic       load;
   run_type    run;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_X_POSITION:   cfg_in.x_position   = csr_wr_data;
            CSR_Y_POSITION:   cfg_in.y_position   = csr_wr_data[5:0];
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wr_data;
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wr_data[6:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
      load      = in_valid_ff && free;
      req_ready = !in_valid_ff || free;
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_position   <= 8'd0;
         cfg_ff.y_position   <= 6'd0;
         cfg_ff.image_width  <= 8'd128;
         cfg_ff.image_height <= 7'd64;
         in_valid_ff         <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_pixel_byte;
      end
   end

   opbc_group_gen u_group_gen (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pixel_byte (in_byte_ff),
      .advance    (load),
      .run        (run)
   );

   opbc_beat_seq u_beat_seq (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .run             (run),
      .free            (free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_data     (rsp_is_data),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
